// ----- rtl/jacd_pkg.sv -----
// ----------------------------------------------------------------------------
// jacd_pkg
// Types and constants shared by the joystick conditioning pipeline.
// ----------------------------------------------------------------------------
package jacd_pkg;

  localparam int RawW  = 8;
  localparam int PosW  = 8;
  localparam int ProdW = 15;   // |d| * gain numerator, at most 255 * 100
  localparam int RcpW  = 14;   // reciprocal constants
  localparam int QuoW  = 9;    // quotient, at most 344
  localparam int RcpSh = 16;   // reciprocal scale, 2^16
  localparam int MagW  = 7;    // conditioned magnitude, 0..100
  localparam int TanW  = 28;   // |axis| * tangent scale

  localparam logic [RawW-1:0] CenterReset = 8'd132;

  // Positive gain x: d / 0.74 = d * 50 / 37; y: d / 0.77 = d * 100 / 77.
  // Negative gain on both axes: d / 1.4 = d * 5 / 7.
  localparam logic [6:0]      NegNum  = 7'd5;
  localparam logic [6:0]      NegDen  = 7'd7;
  localparam logic [RcpW-1:0] NegRcp  = 14'd9362;   // floor(2^16 / 7)

  localparam logic [MagW-1:0] DeadMax  = 7'd4;
  localparam logic [MagW-1:0] ClampMax = 7'd100;
  localparam logic [MagW-1:0] NeutMax  = 7'd79;

  // tan(46 deg) as 1035530 / 1000000
  localparam logic [20:0] TanNum = 21'd1035530;
  localparam logic [20:0] TanDen = 21'd1000000;

  typedef enum logic [0:0] {
    CFG_X_CENTER = 1'b0,
    CFG_Y_CENTER = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_RIGHT   = 3'd1,
    DIR_LEFT    = 3'd2,
    DIR_UP      = 3'd3,
    DIR_DOWN    = 3'd4
  } dir_t;

  typedef struct packed {
    logic [6:0]      pos_num;
    logic [6:0]      pos_den;
    logic [RcpW-1:0] pos_rcp;
  } gain_t;

  localparam gain_t GainX = '{pos_num: 7'd50,  pos_den: 7'd37, pos_rcp: 14'd1771};
  localparam gain_t GainY = '{pos_num: 7'd100, pos_den: 7'd77, pos_rcp: 14'd851};

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- rtl/jacd_axis.sv -----
// ----------------------------------------------------------------------------
// jacd_axis
// Three-stage axis conditioner: center offset and gain product, reciprocal
// quotient estimate, then quotient correction, deadzone and clamp.
// ----------------------------------------------------------------------------
module jacd_axis
  import jacd_pkg::*;
(
  input  logic                   clk,
  input  stage_en_t              en,
  input  gain_t                  gain,
  input  logic [RawW-1:0]        raw,
  input  logic [RawW-1:0]        center,
  output logic signed [PosW-1:0] pos
);

  // stage 1
  logic signed [RawW:0] diff;
  logic [RawW-1:0]      mag_in;
  logic                 neg_in;
  logic [ProdW-1:0]     prod_nxt;
  logic [ProdW-1:0]     prod1_r;
  logic                 neg1_r;

  // stage 2
  logic [RcpW-1:0]       rcp;
  logic [ProdW+RcpW-1:0] scaled;
  logic [QuoW-1:0]       quo2_r;
  logic [ProdW-1:0]      prod2_r;
  logic                  neg2_r;

  // stage 3
  logic [6:0]       den;
  logic [ProdW:0]   back;
  logic [ProdW-1:0] rem;
  logic [QuoW-1:0]  quo;
  logic [MagW-1:0]  mag;
  logic signed [PosW-1:0] pos_nxt;
  logic signed [PosW-1:0] pos_r;

  always_comb begin
    diff     = $signed({1'b0, raw}) - $signed({1'b0, center});
    neg_in   = diff[RawW];
    mag_in   = neg_in ? RawW'(-diff) : diff[RawW-1:0];
    prod_nxt = ProdW'(mag_in * (neg_in ? NegNum : gain.pos_num));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod1_r <= prod_nxt;
      neg1_r  <= neg_in;
    end
  end

  // Reciprocal estimate is at most one below the true quotient.
  always_comb begin
    rcp    = neg1_r ? NegRcp : gain.pos_rcp;
    scaled = prod1_r * rcp;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      quo2_r  <= scaled[RcpSh +: QuoW];
      prod2_r <= prod1_r;
      neg2_r  <= neg1_r;
    end
  end

  always_comb begin
    den  = neg2_r ? NegDen : gain.pos_den;
    back = (ProdW+1)'(quo2_r * den);
    rem  = prod2_r - back[ProdW-1:0];
    quo  = (rem >= ProdW'(den)) ? quo2_r + QuoW'(1) : quo2_r;
    if (quo <= QuoW'(DeadMax)) begin
      mag = '0;
    end else if (quo > QuoW'(ClampMax)) begin
      mag = ClampMax;
    end else begin
      mag = quo[MagW-1:0];
    end
    pos_nxt = neg2_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

// ----- rtl/joystick_axis_condition_direction.sv -----
// ----------------------------------------------------------------------------
// joystick_axis_condition_direction
// Joystick sample conditioning with deadzone, clamp and direction sectors.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat carries raw_x and raw_y, accepted when
// in_valid is high and in_stall is low. Output channel out_*: one beat per
// input beat with pos_x, pos_y (two's complement, -100..100) and direction
// (0 neutral, 1 right, 2 left, 3 up, 4 down), in input order.
// Config port cfg_*: write x_center (index 0) or y_center (index 1) while
// the pipeline is empty; both reset to 132.
// Throughput: one beat per cycle while out_stall is low. An accepted beat
// reaches out_valid through four register stages (gain product, reciprocal
// multiply, quotient correction and clamp, sector compare into the output
// register); the accept edge loads the first. Reset: synchronous, active
// low; clears all stage valid bits and restores the centers. out_stall
// holds an occupied stage only when all stages ahead of it are full; empty
// stages still fill, and in_stall rises only once the first stage is held.
// ----------------------------------------------------------------------------
module joystick_axis_condition_direction
  import jacd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [RawW-1:0]        in_raw_x,
  input  logic [RawW-1:0]        in_raw_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] out_pos_x,
  output logic signed [PosW-1:0] out_pos_y,
  output logic [2:0]             out_direction,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [RawW-1:0]        cfg_data
);

  logic [RawW-1:0] x_center_r;
  logic [RawW-1:0] y_center_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en4;
  stage_en_t en;

  logic signed [PosW-1:0] pos_x3;
  logic signed [PosW-1:0] pos_y3;

  logic [MagW-1:0] ax;
  logic [MagW-1:0] ay;
  logic [TanW-1:0] lhs;
  logic [TanW-1:0] rhs;
  dir_t            dir_nxt;

  logic signed [PosW-1:0] pos_x_r;
  logic signed [PosW-1:0] pos_y_r;
  dir_t                   dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r <= CenterReset;
      y_center_r <= CenterReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_CENTER: x_center_r <= cfg_data;
        CFG_Y_CENTER: y_center_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage ahead advances.
  always_comb begin
    en4   = !v4_r || !out_stall;
    en.s3 = !v3_r || en4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en4)   v4_r <= v3_r;
    end
  end

  jacd_axis u_axis_x (
    .clk    (clk),
    .en     (en),
    .gain   (GainX),
    .raw    (in_raw_x),
    .center (x_center_r),
    .pos    (pos_x3)
  );

  jacd_axis u_axis_y (
    .clk    (clk),
    .en     (en),
    .gain   (GainY),
    .raw    (in_raw_y),
    .center (y_center_r),
    .pos    (pos_y3)
  );

  // Outside the neutral box, horizontal exactly when |y| < tan(46 deg) * |x|.
  always_comb begin
    ax  = pos_x3[PosW-1] ? MagW'(-pos_x3) : pos_x3[MagW-1:0];
    ay  = pos_y3[PosW-1] ? MagW'(-pos_y3) : pos_y3[MagW-1:0];
    lhs = TanW'(ay * TanDen);
    rhs = TanW'(ax * TanNum);
    if (ax <= NeutMax && ay <= NeutMax) begin
      dir_nxt = DIR_NEUTRAL;
    end else if (lhs < rhs) begin
      dir_nxt = pos_x3[PosW-1] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      dir_nxt = pos_y3[PosW-1] ? DIR_DOWN : DIR_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pos_x_r <= pos_x3;
      pos_y_r <= pos_y3;
      dir_r   <= dir_nxt;
    end
  end

  assign out_valid     = v4_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_direction = dir_r;

endmodule

// ----- rtl/jacd_checker.sv -----
// ----------------------------------------------------------------------------
// jacd_checker
// Port-level checks on the conditioned output beats, bound to the top level.
// ----------------------------------------------------------------------------
module jacd_checker
  import jacd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [PosW-1:0] out_pos_x,
  input logic signed [PosW-1:0] out_pos_y,
  input logic [2:0]             out_direction
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) &&
      $stable(out_pos_y) && $stable(out_direction))
    else $error("stalled output beat changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pos_x >= -8'sd100 && out_pos_x <= 8'sd100 &&
      out_pos_y >= -8'sd100 && out_pos_y <= 8'sd100)
    else $error("position outside clamp range");

  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_direction == DIR_NEUTRAL |->
      out_pos_x >= -8'sd79 && out_pos_x <= 8'sd79 &&
      out_pos_y >= -8'sd79 && out_pos_y <= 8'sd79)
    else $error("neutral beat outside neutral box");

  a_horiz_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_direction == DIR_RIGHT || out_direction == DIR_LEFT) |->
      (out_direction == DIR_RIGHT) == (out_pos_x > 8'sd0) && out_pos_x != 8'sd0)
    else $error("horizontal direction disagrees with x sign");

endmodule

bind joystick_axis_condition_direction jacd_checker u_jacd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pos_x     (out_pos_x),
  .out_pos_y     (out_pos_y),
  .out_direction (out_direction)
);

// ----- sim/joystick_axis_condition_direction_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_condition_direction_test
// Self-checking bench for the joystick conditioning pipeline. A short table
// of directed samples (extremes, deadzone, clamp, neutral and sector edges)
// runs first, then random samples over several center settings, each beat
// scored against a local model of gain, deadzone, clamp and direction.
// Both channels idle at random; one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module joystick_axis_condition_direction_test;
  import jacd_pkg::*;

  localparam int XMul         = 50;
  localparam int XDiv         = 37;
  localparam int YMul         = 100;
  localparam int YDiv         = 77;
  localparam int NegMul       = 5;
  localparam int NegDiv       = 7;
  localparam int DeadBand     = 4;
  localparam int PosLimit     = 100;
  localparam int NeutralLimit = 79;
  localparam int Tan46Num     = 1035530;
  localparam int Tan46Den     = 1000000;

  localparam int IdlePct      = 19;
  localparam int NumRows      = 25;
  localparam int NumPhases    = 8;
  localparam int PhaseBeats   = 210;
  localparam int ChokeCycles  = 80;
  localparam int SettleCycles = 8;
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic signed [7:0] px;
    logic signed [7:0] py;
    dir_t              dir;
  } joy_result_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic        typed;
    joy_result_t want;
  } steer_row_t;

  localparam joy_result_t NoWant = '{8'sd0, 8'sd0, DIR_NEUTRAL};

  // Centers are at reset (132) while this table runs.
  localparam steer_row_t SteerRows [0:NumRows-1] = '{
    '{8'd132, 8'd132, 1'b1, '{8'sd0,    8'sd0,    DIR_NEUTRAL}},
    '{8'd255, 8'd132, 1'b1, '{8'sd100,  8'sd0,    DIR_RIGHT}},
    '{8'd0,   8'd132, 1'b1, '{-8'sd94,  8'sd0,    DIR_LEFT}},
    '{8'd132, 8'd255, 1'b1, '{8'sd0,    8'sd100,  DIR_UP}},
    '{8'd132, 8'd0,   1'b1, '{8'sd0,    -8'sd94,  DIR_DOWN}},
    // corners
    '{8'd255, 8'd255, 1'b0, NoWant},
    '{8'd0,   8'd0,   1'b0, NoWant},
    '{8'd255, 8'd0,   1'b0, NoWant},
    '{8'd0,   8'd255, 1'b0, NoWant},
    // deadzone edges: x on both signs, y on the positive side
    '{8'd135, 8'd132, 1'b0, NoWant},
    '{8'd136, 8'd132, 1'b0, NoWant},
    '{8'd126, 8'd132, 1'b0, NoWant},
    '{8'd125, 8'd132, 1'b0, NoWant},
    '{8'd132, 8'd135, 1'b0, NoWant},
    '{8'd132, 8'd136, 1'b0, NoWant},
    // neutral edge, 79 against 80 or 81
    '{8'd191, 8'd132, 1'b0, NoWant},
    '{8'd192, 8'd132, 1'b0, NoWant},
    '{8'd21,  8'd132, 1'b0, NoWant},
    '{8'd20,  8'd132, 1'b0, NoWant},
    '{8'd132, 8'd193, 1'b0, NoWant},
    '{8'd132, 8'd194, 1'b0, NoWant},
    // clamp edge
    '{8'd206, 8'd132, 1'b0, NoWant},
    '{8'd207, 8'd132, 1'b0, NoWant},
    // either side of the 46 degree line
    '{8'd192, 8'd196, 1'b0, NoWant},
    '{8'd192, 8'd197, 1'b0, NoWant}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [RawW-1:0]        in_raw_x = '0;
  logic [RawW-1:0]        in_raw_y = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [PosW-1:0] out_pos_x;
  logic signed [PosW-1:0] out_pos_y;
  logic [2:0]             out_direction;
  logic                   cfg_we = 1'b0;
  logic [0:0]             cfg_index = CFG_X_CENTER;
  logic [RawW-1:0]        cfg_data = '0;

  logic        calm = 1'b0;
  logic        choke_req = 1'b0;
  logic        choke_done = 1'b0;
  int          choke_left = 0;
  int          fault_cnt = 0;
  joy_result_t pending_q [$];

  joystick_axis_condition_direction DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_x      (in_raw_x),
    .in_raw_y      (in_raw_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_direction (out_direction),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [7:0] shape_axis(input logic [7:0] raw,
                                                   input logic [7:0] ctr,
                                                   input int num, input int den);
    int d;
    int v;
    d = int'(raw) - int'(ctr);
    if (d >= 0) begin
      v = d * num / den;
    end else begin
      v = -((-d) * NegMul / NegDiv);
    end
    if (v <= DeadBand && v >= -DeadBand) v = 0;
    if (v > PosLimit) v = PosLimit;
    if (v < -PosLimit) v = -PosLimit;
    return v[7:0];
  endfunction

  function automatic joy_result_t predict_sample(input logic [7:0] rx, input logic [7:0] ry,
                                                 input logic [7:0] cx, input logic [7:0] cy);
    joy_result_t r;
    int ax;
    int ay;
    r.px = shape_axis(rx, cx, XMul, XDiv);
    r.py = shape_axis(ry, cy, YMul, YDiv);
    ax = (r.px < 0) ? -int'(r.px) : int'(r.px);
    ay = (r.py < 0) ? -int'(r.py) : int'(r.py);
    if (ax <= NeutralLimit && ay <= NeutralLimit) begin
      r.dir = DIR_NEUTRAL;
    end else if (ay * Tan46Den < ax * Tan46Num) begin
      if (r.px > 0) r.dir = DIR_RIGHT;
      else r.dir = DIR_LEFT;
    end else begin
      if (r.py > 0) r.dir = DIR_UP;
      else r.dir = DIR_DOWN;
    end
    return r;
  endfunction

  function automatic logic [7:0] to_raw(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Returns at the edge that accepts the beat; valid stays high.
  task automatic send_sample(input logic [7:0] rx, input logic [7:0] ry);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_x <= rx;
    in_raw_y <= ry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  // Receiver: random stall, one long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (choke_left != 0) begin
      out_stall  <= 1'b1;
      choke_left <= choke_left - 1;
    end else if (choke_req && !choke_done) begin
      out_stall  <= 1'b1;
      choke_left <= ChokeCycles - 1;
      choke_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk) begin
    joy_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_fault($sformatf("unexpected beat x=%0d y=%0d dir=%0d",
                             out_pos_x, out_pos_y, out_direction));
      end else begin
        want = pending_q.pop_front();
        if (out_pos_x !== want.px || out_pos_y !== want.py ||
            out_direction !== want.dir) begin
          note_fault($sformatf("expected x=%0d y=%0d dir=%0d, got x=%0d y=%0d dir=%0d",
                               want.px, want.py, want.dir,
                               out_pos_x, out_pos_y, out_direction));
        end
      end
    end
  end

  initial begin
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] rx;
    logic [7:0] ry;
    int         pick;
    int         off;
    cx = CenterReset;
    cy = CenterReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      send_sample(SteerRows[i].rx, SteerRows[i].ry);
      pending_q.push_back(SteerRows[i].typed ? SteerRows[i].want
                                             : predict_sample(SteerRows[i].rx,
                                                              SteerRows[i].ry, cx, cy));
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        // drain before touching the centers
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        case (ph)
          1:       begin cx = 8'd0;   cy = 8'd0;   end
          2:       begin cx = 8'd255; cy = 8'd255; end
          3:       begin cx = 8'd0;   cy = 8'd255; end
          4:       begin cx = 8'd255; cy = 8'd0;   end
          5:       begin cx = 8'd132; cy = 8'd132; end
          default: begin cx = 8'($urandom_range(255)); cy = 8'($urandom_range(255)); end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= CFG_X_CENTER;
        cfg_data  <= cx;
        @(posedge clk);
        cfg_index <= CFG_Y_CENTER;
        cfg_data  <= cy;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      calm <= (ph == 0);

      for (int n = 0; n < PhaseBeats; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          rx = 8'($urandom_range(255));
          ry = 8'($urandom_range(255));
        end else if (pick < 60) begin
          // around rest: deadzone
          rx = to_raw(int'(cx) + int'($urandom_range(24)) - 12);
          ry = to_raw(int'(cy) + int'($urandom_range(24)) - 12);
        end else if (pick < 85) begin
          // off-center band: neutral edge and sector lines
          off = $urandom_range(125, 45);
          rx = to_raw($urandom_range(1) ? int'(cx) + off : int'(cx) - off);
          off = $urandom_range(125, 45);
          ry = to_raw($urandom_range(1) ? int'(cy) + off : int'(cy) - off);
        end else begin
          case ($urandom_range(2))
            0:       rx = 8'd0;
            1:       rx = 8'd255;
            default: rx = cx;
          endcase
          case ($urandom_range(2))
            0:       ry = 8'd0;
            1:       ry = 8'd255;
            default: ry = cy;
          endcase
        end
        if (ph == 1 && n == 40) choke_req <= 1'b1;
        send_sample(rx, ry);
        pending_q.push_back(predict_sample(rx, ry, cx, cy));
      end
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("** joystick_axis_condition_direction: PASSED **");
    end else begin
      $display("** joystick_axis_condition_direction: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** joystick_axis_condition_direction: FAILED **");
    $finish;
  end

endmodule
